// File: src/hfbs_pkg.sv
// Shared types and constants for the HDLC frame bit stuffer.
// No dependencies; imported by every module in src.
package hfbs_pkg;

    // Item kinds on the input channel
    localparam logic [1:0] FUNC_DATA = 2'd0;
    localparam logic [1:0] FUNC_FLAG = 2'd1;
    localparam logic [1:0] FUNC_EOF  = 2'd2;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
    localparam logic [7:0]  FIVE_ONES     = 8'hF8;

    localparam int QUEUE_DEPTH_DEF = 2;

    // One line job handed from the front to the back end
    typedef struct packed {
        logic        stuffed;  // apply zero insertion
        logic        wide;     // 16 bits (FCS) instead of 8
        logic [15:0] bits;     // line bits, first bit in bit 0
    } cmd_t;

endpackage

// File: src/hfbs_front.sv
// Front end: accepts items, runs the CRC and turns func 0-2 into line jobs.
// Depends on hfbs_pkg.
module hfbs_front
    import hfbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [7:0] data_byte,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        accept;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        crc_next      = crc_reg;
        q_push        = 1'b0;
        q_cmd.stuffed = 1'b1;
        q_cmd.wide    = 1'b0;
        q_cmd.bits    = {8'h00, data_byte};
        if (accept)
        begin
            case (func)
                FUNC_DATA:
                begin
                    q_push   = 1'b1;
                    crc_next = crc_byte(crc_reg, data_byte);
                end
                FUNC_FLAG:
                begin
                    q_push        = 1'b1;
                    q_cmd.stuffed = 1'b0;
                    crc_next      = CRC_INIT;
                end
                FUNC_EOF:
                begin
                    // low byte first falls out of sending bit 0 first
                    q_push     = 1'b1;
                    q_cmd.wide = 1'b1;
                    q_cmd.bits = ~crc_reg;
                    crc_next   = CRC_INIT;
                end
                default:
                begin
                    q_push = 1'b0;  // unused code: dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_INIT;
        else
            crc_reg <= crc_next;
    end

endmodule

// File: src/hfbs_queue.sv
// Short job queue between front and back end.
// Depends on hfbs_pkg; DEPTH must be a power of two, at least 2.
module hfbs_queue
    import hfbs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output cmd_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;

    assign full      = (fill_reg == CW'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + CW'(1);
        else if (pop && !push)
            fill_next = fill_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: src/hfbs_back.sv
// Back end: shifts line bits out one per cycle with zero insertion, packs
// bytes, tags each item's last byte; held by output stall. Uses hfbs_pkg.
module hfbs_back
    import hfbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_not_empty,
    input  cmd_t       q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic        busy_reg, busy_next;
    logic        stuffed_reg, stuffed_next;
    logic [4:0]  rem_reg, rem_next;
    logic [15:0] data_reg, data_next;
    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  count_reg, count_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_byte_reg, pend_byte_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        last_reg, last_next;

    logic        out_free;
    logic        load_out;
    logic        load_last;
    logic        do_push;
    logic        push_bit;
    logic        advance;
    logic [7:0]  new_shift;
    logic        completes;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        busy_next       = busy_reg;
        stuffed_next    = stuffed_reg;
        rem_next        = rem_reg;
        data_next       = data_reg;
        shift_next      = shift_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        q_pop           = 1'b0;
        load_out        = 1'b0;
        load_last       = 1'b0;
        do_push         = 1'b0;
        push_bit        = 1'b0;
        advance         = 1'b0;
        new_shift       = {1'b0, shift_reg[7:1]};
        completes       = 1'b0;

        if (!busy_reg)
        begin
            if (q_not_empty)
            begin
                q_pop        = 1'b1;
                busy_next    = 1'b1;
                stuffed_next = q_head.stuffed;
                rem_next     = q_head.wide ? 5'd16 : 5'd8;
                data_next    = q_head.bits;
            end
        end
        else
        begin
            if (stuffed_reg && ((shift_reg & FIVE_ONES) == FIVE_ONES))
            begin
                do_push  = 1'b1;
                push_bit = 1'b0;
            end
            else if (rem_reg != 5'd0)
            begin
                do_push  = 1'b1;
                push_bit = data_reg[0];
                advance  = 1'b1;
            end
            else
            begin
                // item done: held byte goes out as the last of the run
                if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        load_out        = 1'b1;
                        load_last       = 1'b1;
                        pend_valid_next = 1'b0;
                        busy_next       = 1'b0;
                    end
                end
                else
                begin
                    busy_next = 1'b0;
                end
            end

            if (do_push)
            begin
                new_shift = {push_bit, shift_reg[7:1]};
                completes = (count_reg == 3'd7);
                // a new byte displaces the held one; wait if output is busy
                if (!(completes && pend_valid_reg && !out_free))
                begin
                    shift_next = new_shift;
                    count_next = count_reg + 3'd1;
                    if (advance)
                    begin
                        rem_next  = rem_reg - 5'd1;
                        data_next = {1'b0, data_reg[15:1]};
                    end
                    if (completes)
                    begin
                        load_out        = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_byte_next  = new_shift;
                    end
                end
            end
        end

        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = pend_byte_reg;
            last_next      = load_last;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            shift_reg      <= 8'h00;
            count_reg      <= 3'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            shift_reg      <= shift_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stuffed_reg   <= stuffed_next;
        rem_reg       <= rem_next;
        data_reg      <= data_next;
        pend_byte_reg <= pend_byte_next;
        out_byte_reg  <= out_byte_next;
        last_reg      <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

endmodule

// File: src/hdlc_frame_bit_stuffer.sv
// Top level of the HDLC/AX.25 frame encoder with CRC-16-CCITT and bit stuffing.
// Depends on hfbs_pkg, hfbs_front, hfbs_queue and hfbs_back.

// Each transfer in is a data byte (func 0, CRC updated, zero-stuffed), a flag
// byte (func 1, unstuffed, CRC reset) or end of frame (func 2, inverted FCS sent
// low byte first, stuffed, CRC reset); func 3 is dropped. Line bits are packed
// LSB first and each completed byte leaves as one output transfer, with
// last_of_run set on the final byte an input caused; inputs that complete no
// byte produce no output. The back end moves one line bit per cycle while no
// finished byte waits on a stalled output; an item takes a load step, one step
// per line bit (8 or 16 plus inserted zeros) and a closing step.
// A QUEUE_DEPTH-entry job queue lets new items be taken while bits go out.
module hdlc_frame_bit_stuffer
    import hfbs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] func,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_not_empty;
    cmd_t q_cmd;
    cmd_t q_head;

    hfbs_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .data_byte (data_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    hfbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    hfbs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

// File: tb/sv/tb_hdlc_frame_bit_stuffer.sv
// Self-checking testbench for hdlc_frame_bit_stuffer: directed table, then random frames.
// Output bytes are predicted by a CRC-16/bit-stuffing line model kept in this file, or given in the row.
// Depends on hfbs_pkg and the RTL in src.
module tb_hdlc_frame_bit_stuffer;
    import hfbs_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;  // unused selector, dropped by the block

    typedef struct packed {
        logic [7:0] octet;
        logic       last;
    } line_octet_t;

    // Directed row: typed = 1 means the expected bytes are given in the row
    typedef struct packed {
        logic [1:0] f;
        logic [7:0] d;
        logic       typed;
        logic [1:0] n;
        logic [7:0] o;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] func = FUNC_FLAG;
    logic [7:0] data_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       last_of_run;

    // Line model state
    logic [15:0] fcs_acc;
    logic [7:0]  line_shift;
    int unsigned line_cnt;
    logic [7:0]  run_q[$];          // bytes completed by the current item
    line_octet_t pending_octets[$]; // expected output transfers, oldest first
    line_octet_t head;

    int idle_pct = 0;
    int stall_pct = 0;
    int err_cnt = 0;
    int item_cnt = 0;
    int frame_cnt = 0;
    int octet_cnt = 0;

    stim_row_t dir_rows [23] = '{
        '{FUNC_FLAG, 8'h7E, 1'b1, 2'd1, 8'h7E},
        '{FUNC_FLAG, 8'h7E, 1'b1, 2'd1, 8'h7E},
        '{FUNC_NONE, 8'hFF, 1'b1, 2'd0, 8'h00},
        '{FUNC_DATA, 8'h00, 1'b1, 2'd1, 8'h00},
        '{FUNC_DATA, 8'hFF, 1'b0, 2'd0, 8'h00},
        '{FUNC_DATA, 8'hFF, 1'b0, 2'd0, 8'h00},
        '{FUNC_DATA, 8'h1F, 1'b0, 2'd0, 8'h00},  // five ones leading the byte, after two all-ones bytes
        '{FUNC_EOF,  8'h00, 1'b0, 2'd0, 8'h00},
        '{FUNC_FLAG, 8'h7E, 1'b0, 2'd0, 8'h00},
        '{FUNC_EOF,  8'hA5, 1'b0, 2'd0, 8'h00},  // empty frame
        '{FUNC_FLAG, 8'hFF, 1'b0, 2'd0, 8'h00},  // unstuffed ones carried into data
        '{FUNC_DATA, 8'h01, 1'b0, 2'd0, 8'h00},
        '{FUNC_DATA, 8'h80, 1'b0, 2'd0, 8'h00},
        '{FUNC_NONE, 8'h3C, 1'b0, 2'd0, 8'h00},
        '{FUNC_DATA, 8'h7F, 1'b0, 2'd0, 8'h00},
        '{FUNC_DATA, 8'hAA, 1'b0, 2'd0, 8'h00},
        '{FUNC_DATA, 8'h55, 1'b0, 2'd0, 8'h00},
        '{FUNC_DATA, 8'h7E, 1'b0, 2'd0, 8'h00},
        '{FUNC_EOF,  8'hFF, 1'b0, 2'd0, 8'h00},
        '{FUNC_FLAG, 8'h00, 1'b0, 2'd0, 8'h00},
        '{FUNC_FLAG, 8'h7E, 1'b0, 2'd0, 8'h00},
        '{FUNC_DATA, 8'hF8, 1'b0, 2'd0, 8'h00},
        '{FUNC_EOF,  8'h00, 1'b0, 2'd0, 8'h00}
    };

    hdlc_frame_bit_stuffer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    always #5 clk = ~clk;

    function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
        return r;
    endfunction

    // Newest line bit enters at bit 7; a byte is done after eight bits
    function automatic void line_bit(input logic b);
        line_shift = {b, line_shift[7:1]};
        line_cnt++;
        if (line_cnt == 8)
        begin
            line_cnt = 0;
            run_q.push_back(line_shift);
        end
    endfunction

    function automatic logic ones_run();
        return (line_shift & FIVE_ONES) == FIVE_ONES;
    endfunction

    function automatic void line_octet(input logic [7:0] b, input logic stuffed);
        for (int k = 0; k < 8; k++)
        begin
            if (stuffed && ones_run())
                line_bit(1'b0);
            line_bit(b[k]);
        end
        if (stuffed && ones_run())
            line_bit(1'b0);
    endfunction

    function automatic void encode_item(input logic [1:0] f, input logic [7:0] d);
        logic [15:0] fcs;
        run_q.delete();
        case (f)
            FUNC_DATA:
            begin
                fcs_acc = crc_update(fcs_acc, d);
                line_octet(d, 1'b1);
            end
            FUNC_FLAG:
            begin
                line_octet(d, 1'b0);
                fcs_acc = CRC_INIT;
            end
            FUNC_EOF:
            begin
                fcs = ~fcs_acc;
                line_octet(fcs[7:0], 1'b1);
                line_octet(fcs[15:8], 1'b1);
                fcs_acc = CRC_INIT;
            end
            default: ;
        endcase
    endfunction

    task automatic transfer_item(input logic [1:0] f, input logic [7:0] d, input logic typed,
                                 input logic [1:0] n, input logic [7:0] o);
        line_octet_t e;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= f;
        data_byte <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        encode_item(f, d);
        if (typed)
        begin
            run_q.delete();
            if (n != 0)
                run_q.push_back(o);
        end
        foreach (run_q[i])
        begin
            e.octet = run_q[i];
            e.last  = (i == run_q.size() - 1);
            pending_octets.push_back(e);
        end
        item_cnt++;
    endtask

    task automatic drain_line();
        in_valid <= 1'b0;
        while (pending_octets.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed frames with random content; some noise items in between
    task automatic random_frames(input int n_items);
        int sent;
        int n_flags;
        int n_data;
        int sel;
        logic [1:0] f;
        logic [7:0] b;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) < 8)
            begin
                n_flags = $urandom_range(1, 3);
                repeat (n_flags) transfer_item(FUNC_FLAG, 8'h7E, 1'b0, 2'd0, 8'h00);
                n_data = ($urandom_range(9) == 0) ? $urandom_range(8, 24)
                                                  : $urandom_range(0, 6);
                repeat (n_data)
                begin
                    sel = $urandom_range(5);
                    if (sel == 0)
                        b = 8'hFF;
                    else if (sel == 1)
                        b = 8'h7E;
                    else
                        b = 8'($urandom_range(255));
                    transfer_item(FUNC_DATA, b, 1'b0, 2'd0, 8'h00);
                end
                b = 8'($urandom_range(255));
                transfer_item(FUNC_EOF, b, 1'b0, 2'd0, 8'h00);
                sent += n_flags + n_data + 1;
                frame_cnt++;
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    f = 2'($urandom_range(3));
                    b = 8'($urandom_range(255));
                    transfer_item(f, b, 1'b0, 2'd0, 8'h00);
                    if (f != FUNC_NONE)
                        sent++;
                end
            end
        end
    endtask

    // Receiver: check each accepted transfer, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            octet_cnt++;
            if (pending_octets.size() == 0)
            begin
                $error("out_byte: no transfer expected, got %h (last_of_run %b)",
                       out_byte, last_of_run);
                err_cnt++;
            end
            else
            begin
                head = pending_octets.pop_front();
                if (out_byte !== head.octet)
                begin
                    $error("out_byte: expected %h, got %h", head.octet, out_byte);
                    err_cnt++;
                end
                if (last_of_run !== head.last)
                begin
                    $error("last_of_run: expected %b, got %b", head.last, last_of_run);
                    err_cnt++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        #2_000_000;
        $display("Timeout: %0d output bytes still outstanding", pending_octets.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        fcs_acc    = CRC_INIT;
        line_shift = 8'h00;
        line_cnt   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            transfer_item(dir_rows[i].f, dir_rows[i].d, dir_rows[i].typed,
                          dir_rows[i].n, dir_rows[i].o);
        drain_line();

        idle_pct = 0;  stall_pct = 0;
        random_frames(77);
        drain_line();
        idle_pct = 78; stall_pct = 0;
        random_frames(77);
        drain_line();
        idle_pct = 0;  stall_pct = 78;
        random_frames(77);
        drain_line();
        idle_pct = 19; stall_pct = 19;
        random_frames(77);
        drain_line();

        stall_pct = 0;
        repeat (40) @(posedge clk);
        $display("Sent %0d items incl. %0d random frames; checked %0d output bytes",
                 item_cnt, frame_cnt, octet_cnt);
        $display("Phases: free-running, sender gaps, receiver stalls, both mixed");
        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
